### src/c8ic_pkg.sv
// ----------------------------------------------------------------------------
// c8ic_pkg
// Shared constants, stream widths and the hex font of the CHIP-8 core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

  localparam int MEMORY_BYTES  = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int STACK_DEPTH   = 16;
  localparam int PROGRAM_START = 512;
  localparam int FONT_BASE     = 80;
  localparam int FONT_BYTES    = 80;

  localparam int ADDR_W = $clog2(MEMORY_BYTES);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int SP_W   = $clog2(STACK_DEPTH);

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_BITS  = 79;
  localparam int OUT_BITS = 102;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Item kinds.
  localparam logic [2:0] MODE_EXEC    = 3'd0;
  localparam logic [2:0] MODE_TICK    = 3'd1;
  localparam logic [2:0] MODE_MEM_WR  = 3'd2;
  localparam logic [2:0] MODE_MEM_RD  = 3'd3;
  localparam logic [2:0] MODE_ROW_RD  = 3'd4;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage

### src/c8ic_ram.sv
// ----------------------------------------------------------------------------
// c8ic_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One access per cycle: a write, or a read whose data shows next cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

### src/chip8_instruction_core.sv
// Each item goes from dispatch to the result state; an execute item
// that fetches also reads both opcode bytes, Vx and Vy. A draw adds a read and a
// write per sprite row, FX33 a write per digit, FX55 a write and FX65 a read
// and a write per register moved. The next item is accepted only after the result
// transfer; the single main-memory port and the sequencer keep one item in flight.
// After reset the core runs a clearing pass that loads the font and zeroes memory.
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 CPU driven by a stream of execute, timer, memory and display items.
// ----------------------------------------------------------------------------
module chip8_instruction_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // mode[2:0], address[14:3], write_byte[22:15], keys_held[38:23],
  // keys_pressed_now[54:39], keys_released_now[70:55], random_byte[78:71]
  input  logic [c8ic_pkg::IN_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // read_byte[7:0], row_pixels[71:8], next_pc[83:72], last_opcode[99:84],
  // sound_on[100], waiting_key[101]
  output logic [c8ic_pkg::OUT_W-1:0] m_axis_tdata
);
  import c8ic_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_FETCH_HI, ST_FETCH_LO, ST_OPCODE,
    ST_READ_X, ST_READ_Y, ST_EXEC, ST_DRAW_RD, ST_DRAW_WR, ST_BCD,
    ST_STORE, ST_LOAD_RD, ST_LOAD_WR, ST_DONE
  } state_e;

  state_e state_q;

  // Captured input item.
  logic [2:0]  mode_q;
  logic [11:0] addr_in_q;
  logic [7:0]  wbyte_q, rand_q;
  logic [15:0] held_q, pressed_q, released_q;

  // Architectural state.
  logic [7:0]        regs_q  [16];
  logic [11:0]       stack_q [STACK_DEPTH];
  logic [SCREEN_WIDTH-1:0] rows_q [SCREEN_HEIGHT];
  logic [SP_W-1:0]   sp_q;
  logic [15:0]       index_q;
  logic [11:0]       pc_q;
  logic [15:0]       opcode_q;
  logic [7:0]        delay_q, sound_q, opc_hi_q;
  logic              await_press_q, await_release_q;
  logic [3:0]        wait_target_q, held_key_q;

  // Sequencer working registers.
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [3:0]        cnt_q;
  logic [7:0]        vx_q, vy_q;

  // Output register.
  logic              m_valid_q;
  logic [7:0]        rd_byte_q;
  logic [SCREEN_WIDTH-1:0] row_out_q;

  // Main memory port.
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  c8ic_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Opcode fields.
  logic [3:0]  op_x, op_y, op_n;
  logic [7:0]  op_nn;
  logic [11:0] op_nnn;
  assign op_x   = opcode_q[11:8];
  assign op_y   = opcode_q[7:4];
  assign op_n   = opcode_q[3:0];
  assign op_nn  = opcode_q[7:0];
  assign op_nnn = opcode_q[11:0];

  // Single register file read port.
  logic [3:0] reg_ra;
  logic [7:0] reg_rd;
  always_comb begin
    case (state_q)
      ST_READ_X: reg_ra = op_x;
      ST_READ_Y: reg_ra = (opcode_q[15:12] == 4'hB) ? 4'h0 : op_y;
      default:   reg_ra = cnt_q;
    endcase
  end
  assign reg_rd = regs_q[reg_ra];

  // Highest key set in the pressed mask.
  logic       any_pressed;
  logic [3:0] top_key;
  always_comb begin
    top_key = 4'h0;
    for (int k = 0; k < 16; k++) begin
      if (pressed_q[k]) top_key = 4'(k);
    end
  end
  assign any_pressed = |pressed_q;

  // Register ALU for group 8.
  logic [7:0] alu_res;
  logic       alu_flag, alu_wr, alu_fwr;
  logic [8:0] alu_sum;
  always_comb begin
    alu_sum  = {1'b0, vx_q} + {1'b0, vy_q};
    alu_res  = vy_q;
    alu_flag = 1'b0;
    alu_wr   = 1'b1;
    alu_fwr  = 1'b1;
    case (op_n)
      4'h0: alu_fwr = 1'b0;
      4'h1: alu_res = vx_q | vy_q;
      4'h2: alu_res = vx_q & vy_q;
      4'h3: alu_res = vx_q ^ vy_q;
      4'h4: begin alu_res = alu_sum[7:0]; alu_flag = alu_sum[8]; end
      4'h5: begin alu_res = vx_q - vy_q; alu_flag = (vx_q >= vy_q); end
      4'h6: begin alu_res = {1'b0, vx_q[7:1]}; alu_flag = vx_q[0]; end
      4'h7: begin alu_res = vy_q - vx_q; alu_flag = (vy_q >= vx_q); end
      4'hE: begin alu_res = {vx_q[6:0], 1'b0}; alu_flag = vx_q[7]; end
      default: begin alu_wr = 1'b0; alu_fwr = 1'b0; end
    endcase
  end

  // Decimal digits of Vx by compares.
  logic [1:0] bcd_h;
  logic [3:0] bcd_t;
  logic [7:0] bcd_r, bcd_o, bcd_digit;
  always_comb begin
    bcd_h = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
    bcd_r = vx_q - ({6'd0, bcd_h} * 8'd100);
    bcd_t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (bcd_r >= 8'(k * 10)) bcd_t = 4'(k);
    end
    bcd_o = bcd_r - ({4'd0, bcd_t} * 8'd10);
    case (cnt_q[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_h};
      2'd1:    bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = bcd_o;
    endcase
  end

  // Sprite row mask: eight pixels from column Vx, wrapping around the row.
  logic [COL_W-1:0] draw_x0, draw_col;
  logic [ROW_W-1:0] draw_row, row_ra;
  logic [SCREEN_WIDTH-1:0] draw_mask, row_rd;
  always_comb begin
    draw_x0   = vx_q[COL_W-1:0];
    draw_mask = '0;
    draw_col  = '0;
    for (int j = 0; j < 8; j++) begin
      draw_col = draw_x0 + COL_W'(j);
      if (ram_rdata[7-j]) draw_mask[SCREEN_WIDTH-1-int'(draw_col)] = 1'b1;
    end
  end
  assign draw_row = vy_q[ROW_W-1:0] + ROW_W'(cnt_q);
  assign row_ra   = (state_q == ST_DONE) ? addr_in_q[ROW_W-1:0] : draw_row;
  assign row_rd   = rows_q[row_ra];

  logic [15:0] index_cnt;
  assign index_cnt = index_q + 16'(cnt_q);

  // Memory port control.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = index_cnt[ADDR_W-1:0];
    ram_wdata = reg_rd;
    case (state_q)
      ST_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_cnt_q;
        if (clr_cnt_q >= ADDR_W'(FONT_BASE) &&
            clr_cnt_q < ADDR_W'(FONT_BASE + FONT_BYTES)) begin
          ram_wdata = FONT[7'(clr_cnt_q - ADDR_W'(FONT_BASE))];
        end else begin
          ram_wdata = 8'd0;
        end
      end
      ST_DISPATCH: begin
        ram_addr  = addr_in_q;
        ram_wdata = wbyte_q;
        ram_en    = (mode_q == MODE_MEM_WR) || (mode_q == MODE_MEM_RD);
        ram_we    = (mode_q == MODE_MEM_WR);
      end
      ST_FETCH_HI: begin ram_en = 1'b1; ram_addr = pc_q; end
      ST_FETCH_LO: begin ram_en = 1'b1; ram_addr = pc_q + 12'd1; end
      ST_DRAW_RD, ST_LOAD_RD: ram_en = 1'b1;
      ST_STORE: begin ram_en = 1'b1; ram_we = 1'b1; end
      ST_BCD: begin ram_en = 1'b1; ram_we = 1'b1; ram_wdata = bcd_digit; end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !m_valid_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_W - OUT_BITS)'(0),
                          (await_press_q | await_release_q), (sound_q != 8'd0),
                          opcode_q, pc_q, row_out_q, rd_byte_q};

  // Sequencer, architectural state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_cnt_q       <= '0;
      cnt_q           <= '0;
      m_valid_q       <= 1'b0;
      for (int k = 0; k < 16; k++) regs_q[k] <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) stack_q[k] <= '0;
      for (int k = 0; k < SCREEN_HEIGHT; k++) rows_q[k] <= '0;
      sp_q            <= '0;
      index_q         <= '0;
      pc_q            <= 12'(PROGRAM_START);
      opcode_q        <= '0;
      delay_q         <= '0;
      sound_q         <= '0;
      await_press_q   <= 1'b0;
      await_release_q <= 1'b0;
      wait_target_q   <= '0;
      held_key_q      <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ADDR_W'(MEMORY_BYTES - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            mode_q     <= s_axis_tdata[2:0];
            addr_in_q  <= s_axis_tdata[14:3];
            wbyte_q    <= s_axis_tdata[22:15];
            held_q     <= s_axis_tdata[38:23];
            pressed_q  <= s_axis_tdata[54:39];
            released_q <= s_axis_tdata[70:55];
            rand_q     <= s_axis_tdata[78:71];
            state_q    <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          state_q <= ST_DONE;
          if (mode_q == MODE_EXEC) begin
            if (await_press_q) begin
              if (any_pressed) begin
                await_press_q   <= 1'b0;
                await_release_q <= 1'b1;
                held_key_q      <= top_key;
              end
            end else if (await_release_q) begin
              if (released_q[held_key_q]) begin
                regs_q[wait_target_q] <= {4'd0, held_key_q};
                held_key_q      <= '0;
                wait_target_q   <= '0;
                await_release_q <= 1'b0;
              end
            end else begin
              state_q <= ST_FETCH_HI;
            end
          end else if (mode_q == MODE_TICK) begin
            if (delay_q != 8'd0) delay_q <= delay_q - 8'd1;
            if (sound_q != 8'd0) sound_q <= sound_q - 8'd1;
          end
        end
        ST_FETCH_HI: state_q <= ST_FETCH_LO;
        ST_FETCH_LO: begin
          opc_hi_q <= ram_rdata;
          state_q  <= ST_OPCODE;
        end
        ST_OPCODE: begin
          opcode_q <= {opc_hi_q, ram_rdata};
          pc_q     <= pc_q + 12'd2;
          state_q  <= ST_READ_X;
        end
        ST_READ_X: begin
          vx_q    <= reg_rd;
          state_q <= ST_READ_Y;
        end
        ST_READ_Y: begin
          vy_q    <= reg_rd;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= ST_DONE;
          cnt_q   <= '0;
          unique case (opcode_q[15:12])
            4'h0: begin
              if (op_n == 4'h0) begin
                for (int k = 0; k < SCREEN_HEIGHT; k++) rows_q[k] <= '0;
              end else if (op_n == 4'hE) begin
                sp_q <= sp_q - 1'b1;
                pc_q <= stack_q[sp_q - 1'b1];
              end
            end
            4'h1: pc_q <= op_nnn;
            4'h2: begin
              stack_q[sp_q] <= pc_q;
              sp_q          <= sp_q + 1'b1;
              pc_q          <= op_nnn;
            end
            4'h3: if (vx_q == op_nn) pc_q <= pc_q + 12'd2;
            4'h4: if (vx_q != op_nn) pc_q <= pc_q + 12'd2;
            4'h5: if (vx_q == vy_q) pc_q <= pc_q + 12'd2;
            4'h6: regs_q[op_x] <= op_nn;
            4'h7: regs_q[op_x] <= vx_q + op_nn;
            4'h8: begin
              // The flag takes VF when Vx is VF itself.
              if (alu_wr && !(alu_fwr && op_x == 4'hF)) regs_q[op_x] <= alu_res;
              if (alu_fwr) regs_q[15] <= {7'd0, alu_flag};
            end
            4'h9: if (vx_q != vy_q) pc_q <= pc_q + 12'd2;
            4'hA: index_q <= {4'd0, op_nnn};
            4'hB: pc_q <= op_nnn + {4'd0, vy_q};
            4'hC: regs_q[op_x] <= rand_q & op_nn;
            4'hD: begin
              regs_q[15] <= 8'd0;
              if (op_n != 4'h0) state_q <= ST_DRAW_RD;
            end
            4'hE: begin
              if ((op_n == 4'hE && held_q[vx_q[3:0]]) ||
                  (op_n == 4'h1 && !held_q[vx_q[3:0]])) begin
                pc_q <= pc_q + 12'd2;
              end
            end
            4'hF: begin
              case (op_nn)
                8'h07: regs_q[op_x] <= delay_q;
                8'h0A: begin
                  if (any_pressed) begin
                    regs_q[op_x] <= {4'd0, top_key};
                  end else begin
                    await_press_q <= 1'b1;
                    wait_target_q <= op_x;
                  end
                end
                8'h15: delay_q <= vx_q;
                8'h18: sound_q <= vx_q;
                8'h1E: index_q <= index_q + {8'd0, vx_q};
                8'h29: index_q <= 16'(FONT_BASE) + {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
                8'h33: state_q <= ST_BCD;
                8'h55: state_q <= ST_STORE;
                8'h65: state_q <= ST_LOAD_RD;
                default: ;
              endcase
            end
          endcase
        end
        ST_DRAW_RD: state_q <= ST_DRAW_WR;
        ST_DRAW_WR: begin
          if ((row_rd & draw_mask) != '0) regs_q[15] <= 8'd1;
          rows_q[draw_row] <= row_rd ^ draw_mask;
          cnt_q <= cnt_q + 1'b1;
          state_q <= ({1'b0, cnt_q} + 5'd1 == {1'b0, op_n}) ? ST_DONE : ST_DRAW_RD;
        end
        ST_BCD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'd2) state_q <= ST_DONE;
        end
        ST_STORE: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == op_x) state_q <= ST_DONE;
        end
        ST_LOAD_RD: state_q <= ST_LOAD_WR;
        ST_LOAD_WR: begin
          regs_q[cnt_q] <= ram_rdata;
          cnt_q <= cnt_q + 1'b1;
          state_q <= (cnt_q == op_x) ? ST_DONE : ST_LOAD_RD;
        end
        ST_DONE: begin
          m_valid_q <= 1'b1;
          rd_byte_q <= (mode_q == MODE_MEM_RD) ? ram_rdata : 8'd0;
          row_out_q <= (mode_q == MODE_ROW_RD &&
                        addr_in_q < 12'(SCREEN_HEIGHT)) ? row_rd : '0;
          state_q   <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CHIP-8 instruction core. Directed items load a
// small program with draws that wrap, a carry add, a call, a key read and a
// return across pc wrap, then tick the timers; random programs run with bursty
// input and receiver stalls. A behavioral CPU model predicts every result transfer.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c8ic_pkg::*;

  typedef struct packed {
    logic [7:0]  rnd;
    logic [15:0] rel;
    logic [15:0] prs;
    logic [15:0] held;
    logic [7:0]  wbyte;
    logic [11:0] addr;
    logic [2:0]  mode;
  } item_t;

  typedef struct packed {
    logic        waiting;
    logic        sound;
    logic [15:0] opcode;
    logic [11:0] pc;
    logic [63:0] row;
    logic [7:0]  rdata;
  } status_t;

  // CPU model with its own copy of the architectural state.
  class cpu_scoreboard;
    logic [7:0]  mem [MEMORY_BYTES];
    logic [7:0]  v [16];
    logic [11:0] stk [STACK_DEPTH];
    logic [63:0] scr [SCREEN_HEIGHT];
    logic [3:0]  sp;
    logic [15:0] ir;
    logic [11:0] pc;
    logic [15:0] opc;
    logic [7:0]  dly, snd;
    logic        w_press, w_rel;
    logic [3:0]  w_reg, w_key;
    status_t     pending [$];
    int          errors;

    function new();
      for (int a = 0; a < MEMORY_BYTES; a++) mem[a] = 8'h00;
      for (int a = 0; a < FONT_BYTES; a++) mem[FONT_BASE + a] = FONT[a];
      for (int a = 0; a < 16; a++) begin v[a] = 0; stk[a] = 0; end
      for (int a = 0; a < SCREEN_HEIGHT; a++) scr[a] = 0;
      sp = 0; ir = 0; pc = PROGRAM_START; opc = 0; dly = 0; snd = 0;
      w_press = 0; w_rel = 0; w_reg = 0; w_key = 0; errors = 0;
    endfunction

    function void sprite(logic [3:0] x, logic [3:0] y, logic [3:0] n);
      int x0, y0, r, c;
      logic [7:0] bits;
      logic [63:0] m;
      x0 = v[x] % SCREEN_WIDTH;
      y0 = v[y] % SCREEN_HEIGHT;
      v[15] = 0;
      for (int i = 0; i < n; i++) begin
        bits = mem[12'(ir + i)];
        r = (y0 + i) % SCREEN_HEIGHT;
        for (int j = 0; j < 8; j++) begin
          if (bits[7-j]) begin
            c = (x0 + j) % SCREEN_WIDTH;
            m = 64'd1 << (63 - c);
            if (scr[r] & m) v[15] = 1;
            scr[r] ^= m;
          end
        end
      end
    endfunction

    function void run(logic [15:0] op, item_t it);
      logic [3:0]  x, y, lo;
      logic [7:0]  nn, vx, vy;
      logic [8:0]  s;
      logic        down;
      x = op[11:8]; y = op[7:4]; lo = op[3:0]; nn = op[7:0];
      vx = v[x]; vy = v[y];
      case (op[15:12])
        4'h0: if (lo == 4'h0) begin
            for (int a = 0; a < SCREEN_HEIGHT; a++) scr[a] = 0;
          end else if (lo == 4'hE) begin
            sp = sp - 1;
            pc = stk[sp];
          end
        4'h1: pc = op[11:0];
        4'h2: begin stk[sp] = pc; sp = sp + 1; pc = op[11:0]; end
        4'h3: if (vx == nn) pc = pc + 2;
        4'h4: if (vx != nn) pc = pc + 2;
        4'h5: if (vx == vy) pc = pc + 2;
        4'h6: v[x] = nn;
        4'h7: v[x] = vx + nn;
        4'h8: case (lo)
            4'h0: v[x] = vy;
            4'h1: begin v[x] = vx | vy; v[15] = 0; end
            4'h2: begin v[x] = vx & vy; v[15] = 0; end
            4'h3: begin v[x] = vx ^ vy; v[15] = 0; end
            4'h4: begin s = vx + vy; v[x] = s[7:0]; v[15] = s[8]; end
            4'h5: begin v[x] = vx - vy; v[15] = vx >= vy; end
            4'h6: begin v[x] = vx >> 1; v[15] = vx[0]; end
            4'h7: begin v[x] = vy - vx; v[15] = vy >= vx; end
            4'hE: begin v[x] = vx << 1; v[15] = vx[7]; end
            default: ;
          endcase
        4'h9: if (vx != vy) pc = pc + 2;
        4'hA: ir = {4'h0, op[11:0]};
        4'hB: pc = 12'(v[0] + op[11:0]);
        4'hC: v[x] = it.rnd & nn;
        4'hD: sprite(x, y, lo);
        4'hE: begin
          down = it.held[vx[3:0]];
          if ((lo == 4'hE && down) || (lo == 4'h1 && !down)) pc = pc + 2;
        end
        4'hF: case (nn)
            8'h07: v[x] = dly;
            8'h0A: if (it.prs != 0) begin
                for (int k = 0; k < 16; k++) if (it.prs[k]) v[x] = 8'(k);
              end else begin
                w_press = 1; w_reg = x;
              end
            8'h15: dly = vx;
            8'h18: snd = vx;
            8'h1E: ir = ir + vx;
            8'h29: ir = 16'(FONT_BASE + 5 * vx);
            8'h33: begin
              mem[12'(ir + 2)] = vx % 10;
              mem[12'(ir + 1)] = (vx / 10) % 10;
              mem[12'(ir)] = vx / 100;
            end
            8'h55: for (int k = 0; k <= x; k++) mem[12'(ir + k)] = v[k];
            8'h65: for (int k = 0; k <= x; k++) v[k] = mem[12'(ir + k)];
            default: ;
          endcase
        default: ;
      endcase
    endfunction

    // Notes an accepted input transfer and queues the status it should cause.
    function void note_input(item_t it);
      status_t st;
      st = '0;
      case (it.mode)
        MODE_EXEC: begin
          if (w_press) begin
            for (int k = 0; k < 16; k++) if (it.prs[k]) begin
              w_press = 0; w_rel = 1; w_key = 4'(k);
            end
          end else if (w_rel) begin
            if (it.rel[w_key]) begin
              v[w_reg] = {4'h0, w_key}; w_key = 0; w_reg = 0; w_rel = 0;
            end
          end else begin
            opc = {mem[pc], mem[12'(pc + 1)]};
            pc = pc + 2;
            run(opc, it);
          end
        end
        MODE_TICK: begin
          if (dly != 0) dly--;
          if (snd != 0) snd--;
        end
        MODE_MEM_WR: mem[it.addr] = it.wbyte;
        MODE_MEM_RD: st.rdata = mem[it.addr];
        MODE_ROW_RD: if (it.addr < SCREEN_HEIGHT) st.row = scr[it.addr];
        default: ;
      endcase
      st.pc = pc; st.opcode = opc; st.sound = snd != 0; st.waiting = w_press | w_rel;
      pending.push_back(st);
    endfunction

    // Compares one output transfer with the oldest queued status.
    function void check_result(status_t got);
      status_t exp_st;
      if (pending.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      exp_st = pending.pop_front();
      if (got.rdata !== exp_st.rdata) begin
        $error("read_byte exp %h got %h", exp_st.rdata, got.rdata); errors++;
      end
      if (got.row !== exp_st.row) begin
        $error("row_pixels exp %h got %h", exp_st.row, got.row); errors++;
      end
      if (got.pc !== exp_st.pc) begin
        $error("next_pc exp %h got %h", exp_st.pc, got.pc); errors++;
      end
      if (got.opcode !== exp_st.opcode) begin
        $error("last_opcode exp %h got %h", exp_st.opcode, got.opcode); errors++;
      end
      if (got.sound !== exp_st.sound) begin
        $error("sound_on exp %b got %b", exp_st.sound, got.sound); errors++;
      end
      if (got.waiting !== exp_st.waiting) begin
        $error("waiting_key exp %b got %b", exp_st.waiting, got.waiting); errors++;
      end
    endfunction
  endclass

  logic              clk_i, rst_ni;
  logic              s_axis_tvalid, s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  cpu_scoreboard     sb;
  int                cycles;
  int                burst_left;
  bit                stall_mode;

  chip8_instruction_core i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle limit: clearing pass plus a slow worst case per item, many times over.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 800000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver stalls: alternates between free-running and random stall phases.
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Result checking on every output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(status_t'(m_axis_tdata[OUT_BITS-1:0]));
  end

  // Drives one input transfer; valid stays high within a burst and drops in gaps.
  task automatic send(item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
  endtask

  function automatic item_t mk(logic [2:0] mode, logic [11:0] addr = 0,
                               logic [7:0] wb = 0);
    item_t it;
    it = '0;
    it.mode = mode; it.addr = addr; it.wbyte = wb;
    return it;
  endfunction

  task automatic put_word(logic [11:0] a, logic [15:0] w);
    send(mk(MODE_MEM_WR, a, w[15:8]));
    send(mk(MODE_MEM_WR, 12'(a + 1), w[7:0]));
  endtask

  task automatic exec_keys(logic [15:0] held, logic [15:0] prs, logic [15:0] rel);
    item_t it;
    it = mk(MODE_EXEC);
    it.held = held; it.prs = prs; it.rel = rel; it.rnd = 8'($urandom);
    send(it);
  endtask

  // Random instruction, biased toward useful forms within each group and small draws.
  function automatic logic [15:0] rand_op();
    logic [15:0] op;
    logic [7:0]  fsel [12] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33,
                               8'h55, 8'h65, 8'h00, 8'h15, 8'hFF};
    op = 16'($urandom);
    case (op[15:12])
      4'h0: op[11:4] = $urandom_range(0, 3) == 0 ? op[11:4] : 8'h0E;
      4'h1, 4'h2, 4'hB: op[11:8] = $urandom_range(0, 3) ? 4'h2 : op[11:8];
      4'hD: op[3:0] = $urandom_range(0, 7) ? 4'($urandom_range(0, 5)) : op[3:0];
      4'hE: op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
      4'hF: op[7:0] = fsel[$urandom_range(0, 11)];
      default: ;
    endcase
    return op;
  endfunction

  initial begin
    item_t it;
    logic [15:0] op;
    logic [11:0] base;
    sb = new();
    stall_mode = 0; burst_left = 0;
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // Directed program: sets, font address, draw with wrap, carry add, call, key wait, return.
    put_word(12'h200, 16'h60FF);  // V0 = FF
    put_word(12'h202, 16'h613F);  // V1 = 3F (row wrap)
    put_word(12'h204, 16'hF029);  // I = font base + 5 * V0, beyond the font
    put_word(12'h206, 16'hD01F);  // draw 15 rows, wraps both ways
    put_word(12'h208, 16'hD015);  // redraw, 5 rows
    put_word(12'h20A, 16'h8014);  // add with carry
    put_word(12'h20C, 16'h2FFE);  // call near top of memory
    put_word(12'hFFE, 16'hF00A);  // key wait
    put_word(12'h000, 16'h00EE);  // return across pc wrap
    send(mk(MODE_MEM_RD, 12'hFFF));
    send(mk(MODE_MEM_RD, 12'(FONT_BASE)));
    for (int k = 0; k < 6; k++) exec_keys(16'hFFFF, 16'h0, 16'h0);
    exec_keys(16'h0, 16'h0, 16'h0);           // call
    exec_keys(16'h0, 16'h8001, 16'h0);        // key wait, pressed highest key taken at once
    exec_keys(16'h0, 16'h0, 16'h7FFF);        // return across pc wrap
    exec_keys(16'h0, 16'h0, 16'h8000);        // executes 0000 at 20E, clearing the screen
    exec_keys(16'h0, 16'h0, 16'h0);           // executes 0000 at 210, clearing the screen
    send(mk(MODE_ROW_RD, 12'd0));
    send(mk(MODE_ROW_RD, 12'd31));
    send(mk(MODE_ROW_RD, 12'hFFF));
    send(mk(MODE_TICK));
    send(mk(3'd7));

    // Random programs: load a short block, then run it with random inputs.
    for (int blk = 0; blk < 40; blk++) begin
      base = 12'(sb.pc & 12'hFFE);
      for (int k = 0; k < 8; k++) put_word(12'(base + 2 * k), rand_op());
      for (int k = 0; k < 25; k++) begin
        it = item_t'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 15))
          0: it.mode = MODE_TICK;
          1: it.mode = MODE_MEM_RD;
          2: it.mode = MODE_ROW_RD;
          3: it.mode = 3'($urandom_range(5, 7));
          4: it.mode = MODE_MEM_WR;
          default: begin
            it.mode = MODE_EXEC;
            if ($urandom_range(0, 2)) it.prs = 16'(1 << $urandom_range(0, 15));
            if ($urandom_range(0, 3)) it.prs = 0;
          end
        endcase
        if (it.mode == MODE_ROW_RD && $urandom_range(0, 3)) it.addr = $urandom_range(0, 31);
        send(it);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Wait for all results, then a short drain.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

### chip8_instruction_core.f
src/c8ic_pkg.sv
src/c8ic_ram.sv
src/chip8_instruction_core.sv
bench/tb.sv
